// ===== hw/rtl/turtle_pen_plotter_assert.svh =====
// Assertion macros shared by the turtle pen plotter RTL.
// Depends on nothing; the including module must supply i_clk and i_rst_n.
`ifndef TURTLE_PEN_PLOTTER_ASSERT_SVH
`define TURTLE_PEN_PLOTTER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TPP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define TPP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/tpp_pkg.sv =====
// Package for the turtle pen plotter: default grid size, command and heading codes, turn increments.
// Depends on nothing.
package tpp_pkg;

    localparam int GRID_SIZE_DEF = 64;

    localparam logic [2:0] OP_PEN_UP   = 3'd0;
    localparam logic [2:0] OP_PEN_DOWN = 3'd1;
    localparam logic [2:0] OP_TURN_R   = 3'd2;
    localparam logic [2:0] OP_TURN_L   = 3'd3;
    localparam logic [2:0] OP_MOVE     = 3'd4;
    localparam logic [2:0] OP_READ     = 3'd5;

    localparam logic [1:0] HEAD_UP    = 2'd0;
    localparam logic [1:0] HEAD_RIGHT = 2'd1;
    localparam logic [1:0] HEAD_DOWN  = 2'd2;
    localparam logic [1:0] HEAD_LEFT  = 2'd3;

    localparam logic [1:0] TURN_R_INC = 2'd1;
    localparam logic [1:0] TURN_L_INC = 2'd3;

endpackage

// ===== hw/rtl/turtle_pen_plotter.sv =====
// Sequencing: pen and turn commands, pen-up and refused moves go from input transfer
// through S_DONE to the output register; a cell read and a pen-down move first walk the
// bitmap rows in S_WALK (one bitmap row per cycle), a horizontal move a single row.
// Throughput: one command at a time; a vertical pen-down move walks step_count+1 rows,
// at most GRID_SIZE; a new command is taken while the previous result waits.
// Reset (synchronous, active low) sets position 0,0, heading right, pen down, and clears
// the per-row valid bits at once so the whole bitmap reads as zero with no clearing pass.
module turtle_pen_plotter #(
    parameter int GRID_SIZE = tpp_pkg::GRID_SIZE_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // command channel
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [2:0] i_operation,
    input  logic [7:0] i_step_count,
    input  logic [5:0] i_read_row,
    input  logic [5:0] i_read_col,
    // result channel
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_status,
    output logic       o_cell_value,
    output logic [5:0] o_pos_x,
    output logic [5:0] o_pos_y,
    output logic [1:0] o_heading_now
);

    `include "turtle_pen_plotter_assert.svh"

    // Position width and row-count width follow from the grid size.
    localparam int PW = $clog2(GRID_SIZE);
    localparam int CW = $clog2(GRID_SIZE + 1);

    // Sequencer states: take a command, walk the rows, hand off the result.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    // Turtle state
    logic [PW-1:0]        r_col;
    logic [PW-1:0]        r_row;
    logic [1:0]           r_head;
    logic                 r_pen;

    // Sequencer
    logic [1:0]           r_state;
    logic [PW-1:0]        r_rd_row;    // next row to read
    logic [CW-1:0]        r_rd_left;   // rows still to read
    logic                 r_up;        // walk toward row zero
    logic                 r_is_rd;     // walk is a cell read, not a mark
    logic [PW-1:0]        r_col_sel;   // column of the cell read
    logic [GRID_SIZE-1:0] r_mask;      // columns to mark in each walked row
    logic                 r_wr_pend;   // read data for r_wr_row arrives this cycle
    logic [PW-1:0]        r_wr_row;

    // Pending result
    logic                 r_status;
    logic                 r_cell;

    // Output register
    logic                 r_ov;
    logic                 r_o_status;
    logic                 r_o_cell;
    logic [5:0]           r_o_x;
    logic [5:0]           r_o_y;
    logic [1:0]           r_o_head;

    // Bitmap: one row per word, a valid bit per row stands in for the cleared state.
    logic [GRID_SIZE-1:0] r_mem [GRID_SIZE];
    logic [GRID_SIZE-1:0] r_row_vld;
    logic [GRID_SIZE-1:0] r_rdata;
    logic                 r_rvld;

    logic                 w_in_acc;
    logic                 w_rd_en;
    logic                 w_wr_en;
    logic                 w_out_load;
    logic [GRID_SIZE-1:0] w_merge;
    logic [8:0]           w_x9;
    logic [8:0]           w_y9;

    // Move target and marking geometry
    logic                 n_refuse;
    logic [PW-1:0]        n_tx;
    logic [PW-1:0]        n_ty;
    logic [GRID_SIZE-1:0] n_mask;
    logic [CW-1:0]        n_rows;
    logic                 n_vert;
    logic                 n_rd_in;     // requested cell lies inside the grid
    logic [8:0]           w_rrow9;
    logic [8:0]           w_rcol9;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_rd_en    = (r_state == S_WALK) && (r_rd_left != '0);
    assign w_wr_en    = r_wr_pend && !r_is_rd;
    assign w_out_load = (r_state == S_DONE) && (!r_ov || !i_out_stall);

    // Never-written rows read as cleared.
    assign w_merge = (r_rvld ? r_rdata : '0) | r_mask;

    assign w_rrow9 = 9'(i_read_row);
    assign w_rcol9 = 9'(i_read_col);
    assign n_rd_in = (w_rrow9 < 9'(GRID_SIZE)) && (w_rcol9 < 9'(GRID_SIZE));

    always_comb begin
        logic [9:0]    cx10;
        logic [9:0]    cy10;
        logic [9:0]    n10;
        logic [9:0]    t10;
        logic [PW-1:0] lo;
        logic [PW-1:0] hi;
        cx10     = 10'(r_col);
        cy10     = 10'(r_row);
        n10      = 10'(i_step_count);
        t10      = '0;
        n_refuse = 1'b0;
        n_tx     = r_col;
        n_ty     = r_row;
        n_vert   = (r_head == tpp_pkg::HEAD_UP) || (r_head == tpp_pkg::HEAD_DOWN);
        unique case (r_head)
            tpp_pkg::HEAD_UP: begin
                n_refuse = (n10 > cy10);
                t10      = cy10 - n10;
                n_ty     = t10[PW-1:0];
            end
            tpp_pkg::HEAD_RIGHT: begin
                t10      = cx10 + n10;
                n_refuse = (t10 >= 10'(GRID_SIZE));
                n_tx     = t10[PW-1:0];
            end
            tpp_pkg::HEAD_DOWN: begin
                t10      = cy10 + n10;
                n_refuse = (t10 >= 10'(GRID_SIZE));
                n_ty     = t10[PW-1:0];
            end
            default: begin
                n_refuse = (n10 > cx10);
                t10      = cx10 - n10;
                n_tx     = t10[PW-1:0];
            end
        endcase
        // Horizontal moves mark a column span in one row; vertical ones one column per row.
        lo = (n_tx < r_col) ? n_tx : r_col;
        hi = (n_tx < r_col) ? r_col : n_tx;
        for (int j = 0; j < GRID_SIZE; j++) begin
            n_mask[j] = (PW'(j) >= lo) && (PW'(j) <= hi);
        end
        n_rows = n_vert ? CW'(9'(i_step_count) + 9'd1) : CW'(1);
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_col     <= '0;
            r_row     <= '0;
            r_head    <= tpp_pkg::HEAD_RIGHT;
            r_pen     <= 1'b1;
            r_rd_left <= '0;
            r_wr_pend <= 1'b0;
            r_ov      <= 1'b0;
            r_row_vld <= '0;
        end else begin
            // Mark a row as holding real data once it is written back.
            if (w_wr_en) begin
                r_row_vld[r_wr_row] <= 1'b1;
            end

            // Output register: drop on transfer, load when the result is ready.
            if (w_out_load) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        unique case (i_operation)
                            tpp_pkg::OP_PEN_UP: begin
                                r_pen   <= 1'b0;
                                r_state <= S_DONE;
                            end
                            tpp_pkg::OP_PEN_DOWN: begin
                                r_pen   <= 1'b1;
                                r_state <= S_DONE;
                            end
                            tpp_pkg::OP_TURN_R: begin
                                r_head  <= r_head + tpp_pkg::TURN_R_INC;
                                r_state <= S_DONE;
                            end
                            tpp_pkg::OP_TURN_L: begin
                                r_head  <= r_head + tpp_pkg::TURN_L_INC;
                                r_state <= S_DONE;
                            end
                            tpp_pkg::OP_MOVE: begin
                                if (!n_refuse) begin
                                    r_col <= n_tx;
                                    r_row <= n_ty;
                                end
                                // Walk the rows only when the pen leaves marks.
                                if (!n_refuse && r_pen) begin
                                    r_state   <= S_WALK;
                                    r_rd_left <= n_rows;
                                end else begin
                                    r_state <= S_DONE;
                                end
                            end
                            tpp_pkg::OP_READ: begin
                                if (n_rd_in) begin
                                    r_state   <= S_WALK;
                                    r_rd_left <= CW'(1);
                                end else begin
                                    r_state <= S_DONE;
                                end
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_WALK: begin
                    // Read one row a cycle; write it back the cycle after, unless the walk is a cell read.
                    r_wr_pend <= w_rd_en;
                    if (w_rd_en) begin
                        r_rd_left <= r_rd_left - CW'(1);
                    end
                    if (!w_rd_en && !r_wr_pend) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Walk payload and pending result
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_status  <= (i_operation == tpp_pkg::OP_MOVE) && n_refuse;
            r_cell    <= 1'b0;
            r_is_rd   <= (i_operation == tpp_pkg::OP_READ);
            r_col_sel <= w_rcol9[PW-1:0];
            r_mask    <= n_mask;
            r_up      <= (r_head == tpp_pkg::HEAD_UP);
            r_rd_row  <= (i_operation == tpp_pkg::OP_READ) ? w_rrow9[PW-1:0] : r_row;
        end else if (w_rd_en) begin
            r_rd_row <= r_up ? r_rd_row - PW'(1) : r_rd_row + PW'(1);
        end
        if (w_rd_en) begin
            r_wr_row <= r_rd_row;
        end
        if (r_wr_pend && r_is_rd) begin
            r_cell <= r_rvld && r_rdata[r_col_sel];
        end
    end

    // Bitmap memory: one read and one write port, registered read data.
    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rdata <= r_mem[r_rd_row];
            r_rvld  <= r_row_vld[r_rd_row];
        end
        if (w_wr_en) begin
            r_mem[r_wr_row] <= w_merge;
        end
    end

    // Output payload: positions carry their low six bits.
    assign w_x9 = 9'(r_col);
    assign w_y9 = 9'(r_row);

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_o_status <= r_status;
            r_o_cell   <= r_cell;
            r_o_x      <= w_x9[5:0];
            r_o_y      <= w_y9[5:0];
            r_o_head   <= r_head;
        end
    end

    assign o_out_valid   = r_ov;
    assign o_status      = r_o_status;
    assign o_cell_value  = r_o_cell;
    assign o_pos_x       = r_o_x;
    assign o_pos_y       = r_o_y;
    assign o_heading_now = r_o_head;

    `TPP_ASSERT_NOW(a_wr_only_in_walk, r_wr_pend, r_state == S_WALK, "write-back outside walk")
    `TPP_ASSERT_NOW(a_idle_no_reads, r_state == S_IDLE, r_rd_left == '0, "rows left while idle")
    `TPP_ASSERT_NEXT(a_done_loads, w_out_load, r_ov && (r_state == S_IDLE), "result not loaded")
    `TPP_ASSERT_NOW(a_pos_in_grid, 1'b1,
                    (r_col <= PW'(GRID_SIZE - 1)) && (r_row <= PW'(GRID_SIZE - 1)),
                    "turtle left the grid")

endmodule
